[design/utf8_stream_decoder_macros.svh]
// Assertion macros used by the checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define U8D_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define U8D_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/u8d_pkg.sv]
package u8d_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CodeWidth  = 22;
   localparam int unsigned TakenWidth = 3;

   // One result as it is queued for the output.
   typedef struct packed {
      logic [CodeWidth-1:0]  code;
      logic [TakenWidth-1:0] taken;
      logic                  err;
      logic                  last;
   } u8d_result_type;

   // Pending sequence: lead byte, held continuation count and total length.
   typedef struct packed {
      logic [ByteWidth-1:0] lead;
      logic [1:0]           held;
      logic [2:0]           needed;
   } u8d_ctrl_type;

   typedef logic [1:0][ByteWidth-1:0] u8d_cont_type;

   // Sequence length from a lead byte; zero marks a byte that cannot lead.
   function automatic logic [2:0] seq_length(input logic [ByteWidth-1:0] b);
      logic [2:0] n;
      if (!b[7])      n = 3'd1;
      else if (!b[6]) n = 3'd0;
      else if (!b[5]) n = 3'd2;
      else if (!b[4]) n = 3'd3;
      else if (!b[3]) n = 3'd4;
      else            n = 3'd0;
      return n;
   endfunction

   // A bad byte is reported as its value negated.
   function automatic u8d_result_type bad_byte(input logic [ByteWidth-1:0] b);
      u8d_result_type r;
      r.code  = CodeWidth'(0) - {{(CodeWidth-ByteWidth){1'b0}}, b};
      r.taken = TakenWidth'(1);
      r.err   = 1'b1;
      r.last  = 1'b0;
      return r;
   endfunction

endpackage

[design/utf8_stream_decoder.sv]
// Latency: a byte that completes a code point or fails shows its first result
// on the cycle after it is accepted; bytes held inside a sequence give none.
// Throughput: one byte per cycle while each byte gives at most one result and the
// receiver is ready; a byte that gives a burst of k results (up to four) holds the
// input until the last of its results is being taken.
// Reset (synchronous, active high) drops any pending sequence and queued results.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   // Request side: one raw byte per request.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_input
   // Result side: one decoded code point or error per transfer.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [21:0] code_value, [24:22] bytes_taken, rest zero
   output logic        rsp_tuser,   // is_error
   output logic        rsp_tlast    // last_of_run
);
   import u8d_pkg::*;

   // Decoder state. The control part resets; the held continuation bytes are
   // only read when the held count says they were written, so they do not.
   u8d_ctrl_type ctrl_ff, ctrl_in;
   u8d_cont_type cont_ff, cont_in;

   // Result burst buffer: all results of one request are loaded at once and drained one
   // per cycle from head_ff while the receiver is ready. left_ff counts what is still queued.
   u8d_result_type [3:0] slot_ff, slot_in;
   logic [2:0]           left_ff, left_in;
   logic [1:0]           head_ff, head_in;

   u8d_result_type [3:0] step_results;
   logic [2:0]           step_count;
   logic                 req_fire;
   logic                 rsp_fire;
   u8d_result_type       head_result;

   u8d_step u_step (
      .data_byte    (req_tdata),
      .end_of_input (req_tlast),
      .ctrl_cur     (ctrl_ff),
      .cont_cur     (cont_ff),
      .ctrl_nxt     (ctrl_in),
      .cont_nxt     (cont_in),
      .results      (step_results),
      .result_count (step_count)
   );

   assign rsp_fire = rsp_tvalid && rsp_tready;
   // A new request is taken when the buffer is empty or its last entry leaves
   // in this same cycle, so single results stream at full rate.
   assign req_tready = (left_ff == 3'd0) || (left_ff == 3'd1 && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      slot_in = slot_ff;
      left_in = left_ff;
      head_in = head_ff;
      if (rsp_fire) begin
         left_in = left_ff - 3'd1;
         head_in = head_ff + 2'd1;
      end
      if (req_fire) begin
         slot_in = step_results;
         left_in = step_count;
         head_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         left_ff <= 3'd0;
         head_ff <= 2'd0;
      end else begin
         if (req_fire) begin
            ctrl_ff <= ctrl_in;
         end
         left_ff <= left_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cont_ff <= cont_in;
      end
      slot_ff <= slot_in;
   end

   assign head_result = slot_ff[head_ff];
   assign rsp_tvalid  = (left_ff != 3'd0);
   assign rsp_tdata   = {7'd0, head_result.taken, head_result.code};
   assign rsp_tuser   = head_result.err;
   assign rsp_tlast   = head_result.last;

endmodule

[design/u8d_step.sv]
module u8d_step (
   input  logic [7:0]             data_byte,
   input  logic                   end_of_input,
   input  u8d_pkg::u8d_ctrl_type  ctrl_cur,
   input  u8d_pkg::u8d_cont_type  cont_cur,
   output u8d_pkg::u8d_ctrl_type  ctrl_nxt,
   output u8d_pkg::u8d_cont_type  cont_nxt,
   output u8d_pkg::u8d_result_type [3:0] results,
   output logic [2:0]             result_count
);
   import u8d_pkg::*;

   logic         is_cont;
   logic [2:0]   fresh_len;
   logic [20:0]  cp;
   u8d_ctrl_type fl_ctrl;
   u8d_cont_type fl_cont;
   logic         do_flush;
   logic         do_fresh;
   logic [2:0]   k;

   assign is_cont   = (data_byte[7:6] == 2'b10);
   assign fresh_len = seq_length(data_byte);

   always_comb begin
      unique case (ctrl_cur.needed)
         3'd2:    cp = {10'd0, ctrl_cur.lead[4:0], data_byte[5:0]};
         3'd3:    cp = {5'd0, ctrl_cur.lead[3:0], cont_cur[0][5:0], data_byte[5:0]};
         default: cp = {ctrl_cur.lead[2:0], cont_cur[0][5:0], cont_cur[1][5:0],
                        data_byte[5:0]};
      endcase
   end

   always_comb begin
      ctrl_nxt = ctrl_cur;
      cont_nxt = cont_cur;
      results  = '0;
      k        = 3'd0;
      fl_ctrl  = ctrl_cur;
      fl_cont  = cont_cur;
      do_flush = 1'b0;
      do_fresh = 1'b0;

      if (ctrl_cur.needed == 3'd0) begin
         do_fresh = 1'b1;
      end else if (is_cont) begin
         if (({1'b0, ctrl_cur.held} + 3'd2) >= ctrl_cur.needed) begin
            results[0].code  = {1'b0, cp};
            results[0].taken = ctrl_cur.needed;
            k                = 3'd1;
            ctrl_nxt         = '0;
         end else begin
            cont_nxt[ctrl_cur.held[0]] = data_byte;
            ctrl_nxt.held              = ctrl_cur.held + 2'd1;
            if (end_of_input) begin
               // Cut off by the end of the stream: flush including this byte.
               fl_ctrl  = ctrl_nxt;
               fl_cont  = cont_nxt;
               do_flush = 1'b1;
            end
         end
      end else begin
         do_flush = 1'b1;
         do_fresh = 1'b1;
      end

      if (do_flush) begin
         results[k[1:0]] = bad_byte(fl_ctrl.lead);
         k = k + 3'd1;
         if (fl_ctrl.held >= 2'd1) begin
            results[k[1:0]] = bad_byte(fl_cont[0]);
            k = k + 3'd1;
         end
         if (fl_ctrl.held >= 2'd2) begin
            results[k[1:0]] = bad_byte(fl_cont[1]);
            k = k + 3'd1;
         end
         ctrl_nxt = '0;
      end

      if (do_fresh) begin
         if (fresh_len == 3'd1) begin
            results[k[1:0]].code  = {14'd0, data_byte};
            results[k[1:0]].taken = 3'd1;
            k = k + 3'd1;
         end else if (fresh_len == 3'd0 || end_of_input) begin
            results[k[1:0]] = bad_byte(data_byte);
            k = k + 3'd1;
         end else begin
            ctrl_nxt.lead   = data_byte;
            ctrl_nxt.held   = 2'd0;
            ctrl_nxt.needed = fresh_len;
         end
      end

      if (k != 3'd0) begin
         results[k[1:0] - 2'd1].last = 1'b1;
      end
      result_count = k;
   end

endmodule

[design/u8d_checker.sv]
`include "utf8_stream_decoder_macros.svh"

module u8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // Errors always consume exactly one byte.
   `U8D_ASSERT_NOW(a_err_one_byte, clock, reset,
      rsp_tvalid && rsp_tuser, rsp_tdata[24:22] == 3'd1,
      "error result with bytes_taken other than one")

   // Only bytes of 0x80 and up can fail, so an error code lies in -255 to -128.
   `U8D_ASSERT_NOW(a_err_range, clock, reset,
      rsp_tvalid && rsp_tuser,
      rsp_tdata[21:0] >= 22'h3FFF01 && rsp_tdata[21:0] <= 22'h3FFF80,
      "error code outside the negated high-byte range")

   // A single-byte code point is plain ASCII.
   `U8D_ASSERT_NOW(a_ascii, clock, reset,
      rsp_tvalid && !rsp_tuser && rsp_tdata[24:22] == 3'd1, rsp_tdata[21:7] == 15'd0,
      "one-byte code point above 0x7F")

   // The unused top bits of tdata stay zero.
   `U8D_ASSERT_NOW(a_tdata_pad, clock, reset,
      rsp_tvalid, rsp_tdata[31:25] == 7'd0,
      "nonzero tdata padding")

   // A stalled result stays put.
   `U8D_ASSERT_NEXT(a_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result changed")

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
